@@ rtl/core/pidaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, register map, reset values and saturation helpers for the
// PID controller with direction-dependent integral clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

    localparam int VALUE_W = 32;           // Q16.16 values
    localparam int GAIN_W  = 16;           // unsigned gains
    localparam int POINT_W = 16;           // fraction bits of a value
    localparam int ROUND_W = VALUE_W - POINT_W;
    localparam int SUM_W   = VALUE_W + 2;  // room for a three-term sum
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    typedef logic signed [VALUE_W-1:0] t_val;
    typedef logic        [GAIN_W-1:0]  t_gain;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [ROUND_W-1:0] t_round;

    typedef enum logic [IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_UPPER     = 3'd4,
        REG_LOWER     = 3'd5,
        REG_NEGATIVE  = 3'd6,
        REG_OFFSET    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_val  setpoint;
        t_gain gain_p;
        t_gain gain_i;
        t_gain gain_d;
        t_val  upper_limit;
        t_val  lower_limit;
        t_val  negative_limit;
        t_val  drive_offset;
    } t_cfg;

    localparam t_val  RST_SETPOINT = 32'sd0;
    localparam t_gain RST_GAIN_P   = 16'd10240;  // 2.5
    localparam t_gain RST_GAIN_I   = 16'd10240;  // 2.5
    localparam t_gain RST_GAIN_D   = 16'd410;    // about 0.1
    localparam t_val  RST_UPPER    = 32'sd65536000;
    localparam t_val  RST_LOWER    = 32'sd0;
    localparam t_val  RST_NEGATIVE = -32'sd65536000;
    localparam t_val  RST_OFFSET   = 32'sd0;

    localparam t_val VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Saturate a widened sum back to value width.
    function automatic t_val sat_sum(input t_sum v);
        logic [SUM_W-VALUE_W:0] top;
        t_val res;
        top = v[SUM_W-1:VALUE_W-1];
        if ((&top) || !(|top)) begin
            res = v[VALUE_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

    // High bound is tested first; inverted window: hi above it, lo otherwise.
    function automatic t_val clamp_win(input t_val v, input t_val lo, input t_val hi);
        t_val res;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pidaw_meas_if.sv @@
// ----------------------------------------------------------------------------
// pidaw_meas_if
// Valid/ready channel carrying one measured sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidaw_meas_if
    import pidaw_pkg::*;
();
    logic valid;
    logic ready;
    t_val measured;

    modport source (output valid, output measured, input ready);
    modport sink   (input valid, input measured, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pidaw_drive_if.sv @@
// ----------------------------------------------------------------------------
// pidaw_drive_if
// Valid/ready channel carrying the fixed-point and rounded drive per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidaw_drive_if
    import pidaw_pkg::*;
();
    logic   valid;
    logic   ready;
    t_val   drive_fixed;
    t_round drive_rounded;

    modport source (output valid, output drive_fixed, output drive_rounded, input ready);
    modport sink   (input valid, input drive_fixed, input drive_rounded, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pid_antiwindup_direction_clamp_top.sv @@
// ----------------------------------------------------------------------------
// pid_antiwindup_direction_clamp_top
// PID controller with direction-dependent integral clamp, APB register port.
// ----------------------------------------------------------------------------
// Takes one measured sample per beat and returns one drive beat per sample.
// Throughput is one sample per clock while the receiver is ready. A sample is accepted into the input
// register and moves into the result register when that slot is free or
// draining; its drive beat is presented from the result register. The whole
// PID update is done in the single pass between the two registers. The
// input stalls only while both registers hold a beat and the receiver is
// not ready. The integral and previous error advance exactly when a sample
// moves into the result register. Registers sit at byte address 4*index:
// setpoint, gain_p, gain_i, gain_d, upper_limit, lower_limit,
// negative_limit, drive_offset. Write them only while no sample is in flight.
`default_nettype none

module pid_antiwindup_direction_clamp_top
    import pidaw_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    pidaw_meas_if.sink               i_meas,
    pidaw_drive_if.source            o_drive,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready
);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_val     r_meas;
    logic     r_out_valid;
    logic     advance;
    logic     in_ready;
    logic     cfg_wr;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint       <= RST_SETPOINT;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.upper_limit    <= RST_UPPER;
            r_cfg.lower_limit    <= RST_LOWER;
            r_cfg.negative_limit <= RST_NEGATIVE;
            r_cfg.drive_offset   <= RST_OFFSET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SETPOINT: r_cfg.setpoint       <= pwdata[VALUE_W-1:0];
                REG_GAIN_P:   r_cfg.gain_p         <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:   r_cfg.gain_i         <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:   r_cfg.gain_d         <= pwdata[GAIN_W-1:0];
                REG_UPPER:    r_cfg.upper_limit    <= pwdata[VALUE_W-1:0];
                REG_LOWER:    r_cfg.lower_limit    <= pwdata[VALUE_W-1:0];
                REG_NEGATIVE: r_cfg.negative_limit <= pwdata[VALUE_W-1:0];
                REG_OFFSET:   r_cfg.drive_offset   <= pwdata[VALUE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SETPOINT: prdata = r_cfg.setpoint;
            REG_GAIN_P:   prdata = DATA_W'(r_cfg.gain_p);
            REG_GAIN_I:   prdata = DATA_W'(r_cfg.gain_i);
            REG_GAIN_D:   prdata = DATA_W'(r_cfg.gain_d);
            REG_UPPER:    prdata = r_cfg.upper_limit;
            REG_LOWER:    prdata = r_cfg.lower_limit;
            REG_NEGATIVE: prdata = r_cfg.negative_limit;
            REG_OFFSET:   prdata = r_cfg.drive_offset;
        endcase
    end

    // Sample moves to the result register when that slot is free or draining.
    assign advance      = r_in_valid && (!r_out_valid || o_drive.ready);
    assign in_ready     = !r_in_valid || advance;
    assign i_meas.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= (r_in_valid && !advance) || (i_meas.valid && in_ready);
            r_out_valid <= advance || (r_out_valid && !o_drive.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_meas.valid && in_ready) begin
            r_meas <= i_meas.measured;
        end
    end

    pidaw_core #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_measured      (r_meas),
        .i_cfg           (r_cfg),
        .o_drive_fixed   (o_drive.drive_fixed),
        .o_drive_rounded (o_drive.drive_rounded)
    );

    assign o_drive.valid = r_out_valid;

    // A beat that moves forward always shows up at the output next cycle.
    a_advance_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced beat did not reach the output");

    // A held sample is never dropped while the output is stalled.
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_drive.ready) |=> r_in_valid)
        else $error("pending sample lost under output stall");

    // Input side only backs up when a sample is held and cannot move.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_in_valid && r_out_valid && !o_drive.ready))
        else $error("input ready dropped without a stall");

    // A stalled result keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_drive.ready) |=> $stable(o_drive.drive_fixed))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ rtl/core/pidaw_core.sv @@
// ----------------------------------------------------------------------------
// pidaw_core
// PID datapath: error, three gain products, clamped integral, clamped sum,
// offset and rounding, with integral and previous-error state.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_core
    import pidaw_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_advance,
    input  wire t_val   i_measured,
    input  wire t_cfg   i_cfg,
    output t_val        o_drive_fixed,
    output t_round      o_drive_rounded
);

    localparam int PROD_W = VALUE_W + GAIN_W + 1;

    t_val r_integral;
    t_val r_prev_err;
    t_val r_drive_fixed;
    t_round r_drive_rounded;

    t_val   err;
    t_val   diff;
    t_val   prop;
    t_val   integ_term;
    t_val   deriv;
    t_val   lo;
    t_val   hi;
    t_val   n_integral;
    t_val   sum_clamped;
    t_val   drive;
    logic signed [ROUND_W:0] whole;
    t_round n_rounded;

    // Floor-shift the exact product and saturate to value width.
    function automatic t_val scale(input t_val v, input t_gain g);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sh;
        logic [PROD_W-VALUE_W:0] top;
        t_val res;
        prod = v * $signed({1'b0, g});
        sh   = prod >>> GAIN_FRAC_BITS;
        top  = sh[PROD_W-1:VALUE_W-1];
        if ((&top) || !(|top)) begin
            res = sh[VALUE_W-1:0];
        end else if (sh[PROD_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

    always_comb begin
        err  = sat_sum(SUM_W'(i_cfg.setpoint) - SUM_W'(i_measured));
        diff = sat_sum(SUM_W'(err) - SUM_W'(r_prev_err));

        prop       = scale(err, i_cfg.gain_p);
        integ_term = scale(err, i_cfg.gain_i);
        deriv      = scale(diff, i_cfg.gain_d);

        // Window follows the sign of the setpoint.
        if (!i_cfg.setpoint[VALUE_W-1]) begin
            lo = i_cfg.lower_limit;
            hi = i_cfg.upper_limit;
        end else begin
            lo = i_cfg.negative_limit;
            hi = i_cfg.lower_limit;
        end

        n_integral  = clamp_win(sat_sum(SUM_W'(r_integral) + SUM_W'(integ_term)), lo, hi);
        sum_clamped = clamp_win(sat_sum(SUM_W'(prop) + SUM_W'(n_integral) + SUM_W'(deriv)),
                                lo, hi);
        drive       = sat_sum(SUM_W'(sum_clamped) + SUM_W'(i_cfg.drive_offset));

        // Round up only when the fraction is strictly above one half.
        whole = (ROUND_W+1)'($signed(drive[VALUE_W-1:POINT_W]))
              + (ROUND_W+1)'(drive[POINT_W-1:0] > {1'b1, {(POINT_W-1){1'b0}}});
        if (whole[ROUND_W] != whole[ROUND_W-1]) begin
            n_rounded = {1'b0, {(ROUND_W-1){1'b1}}};
        end else begin
            n_rounded = whole[ROUND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_advance) begin
            r_integral <= n_integral;
            r_prev_err <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_drive_fixed   <= drive;
            r_drive_rounded <= n_rounded;
        end
    end

    assign o_drive_fixed   = r_drive_fixed;
    assign o_drive_rounded = r_drive_rounded;

endmodule

`default_nettype wire

@@ bench/pidaw_bench_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidaw_bench_pkg
// Drive predictor and scoreboard for the PID controller with direction clamp.
// Mirrors the register file and the integral / previous-error state, works
// out the drive beat for every accepted sample, and checks returned beats in
// order against it.
// ----------------------------------------------------------------------------

package pidaw_bench_pkg;

    import pidaw_pkg::*;

    localparam int GAIN_SHIFT = 12;  // matches the top level's default

    typedef struct {
        t_val   fixed;
        t_round rounded;
    } t_drive_beat;

    class pid_drive_scoreboard;

        t_cfg        cfg;
        longint      integral;
        longint      prev_err;
        t_drive_beat expected_drives[$];
        int unsigned errors;

        function new();
            cfg = '{RST_SETPOINT, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D,
                    RST_UPPER, RST_LOWER, RST_NEGATIVE, RST_OFFSET};
            integral = 0;
            prev_err = 0;
            errors   = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_SETPOINT: cfg.setpoint       = data;
                REG_GAIN_P:   cfg.gain_p         = data[GAIN_W-1:0];
                REG_GAIN_I:   cfg.gain_i         = data[GAIN_W-1:0];
                REG_GAIN_D:   cfg.gain_d         = data[GAIN_W-1:0];
                REG_UPPER:    cfg.upper_limit    = data;
                REG_LOWER:    cfg.lower_limit    = data;
                REG_NEGATIVE: cfg.negative_limit = data;
                REG_OFFSET:   cfg.drive_offset   = data;
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > longint'(VAL_MAX)) begin
                return longint'(VAL_MAX);
            end
            if (v < longint'(VAL_MIN)) begin
                return longint'(VAL_MIN);
            end
            return v;
        endfunction

        // exact product, floor shift, then saturate
        function longint gain_term(longint v, t_gain g);
            longint prod;
            prod = v * longint'(g);
            return sat32(prod >>> GAIN_SHIFT);
        endfunction

        // high bound is tested first: on an inverted window, values above it get hi, others lo
        function longint window(longint v, longint lo, longint hi);
            if (v > hi) begin
                return hi;
            end
            if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        function void note_sample(t_val meas);
            longint      err;
            longint      prop;
            longint      deriv;
            longint      lo;
            longint      hi;
            longint      total;
            longint      drive;
            longint      whole;
            t_drive_beat beat;
            err   = sat32(longint'(cfg.setpoint) - longint'(meas));
            prop  = gain_term(err, cfg.gain_p);
            deriv = gain_term(sat32(err - prev_err), cfg.gain_d);
            if (cfg.setpoint >= 0) begin
                lo = cfg.lower_limit;
                hi = cfg.upper_limit;
            end else begin
                lo = cfg.negative_limit;
                hi = cfg.lower_limit;
            end
            integral = sat32(integral + gain_term(err, cfg.gain_i));
            integral = window(integral, lo, hi);
            total    = window(sat32(prop + integral + deriv), lo, hi);
            drive    = sat32(total + longint'(cfg.drive_offset));
            prev_err = err;
            // round up only when the fraction is strictly above one half
            whole = drive >>> POINT_W;
            if (drive[POINT_W-1:0] > 16'h8000) begin
                whole = whole + 1;
            end
            if (whole > 32767) begin
                whole = 32767;
            end
            if (whole < -32768) begin
                whole = -32768;
            end
            beat.fixed   = t_val'(drive);
            beat.rounded = t_round'(whole);
            expected_drives.push_back(beat);
        endfunction

        function void check_drive(t_val fixed, t_round rounded);
            t_drive_beat want;
            if (expected_drives.size() == 0) begin
                errors++;
                $display("%0t: drive beat with none expected: fixed=%0d rounded=%0d",
                         $time, fixed, rounded);
                return;
            end
            want = expected_drives.pop_front();
            if (fixed !== want.fixed) begin
                errors++;
                $display("%0t: drive_fixed mismatch: expected %0d actual %0d",
                         $time, want.fixed, fixed);
            end
            if (rounded !== want.rounded) begin
                errors++;
                $display("%0t: drive_rounded mismatch: expected %0d actual %0d",
                         $time, want.rounded, rounded);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

    endclass

endpackage

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pid_antiwindup_direction_clamp_top.
// Drives directed corner samples, then random segments with fresh register
// settings, sender/receiver idling in three phases and two long receiver
// hold-offs; every drive beat is checked against the scoreboard's predictor.
// ----------------------------------------------------------------------------

module testbench;

    import pidaw_pkg::*;
    import pidaw_bench_pkg::*;

    localparam int N_SEGMENTS  = 22;
    localparam int SEG_SAMPLES = 75;
    localparam int HOLD_CYCLES = 160;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_req;
    int unsigned hold_left;

    pidaw_meas_if  meas_if();
    pidaw_drive_if drive_if();

    pid_drive_scoreboard sb = new();

    pid_antiwindup_direction_clamp_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas_if),
        .o_drive (drive_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("pid_antiwindup_direction_clamp_top verification failed");
        $finish;
    end

    // receiver: random ready, or a counted hold-off on request
    initial begin
        drive_if.ready = 1'b0;
        hold_left      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                drive_if.ready = 1'b0;
                hold_left--;
            end else begin
                drive_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            sb.check_drive(drive_if.drive_fixed, drive_if.drive_rounded);
        end
    end

    // entered and left at a falling edge
    task automatic send_sample(input t_val meas);
        while ($urandom_range(99) < send_idle_pct) begin
            meas_if.valid = 1'b0;
            @(negedge i_clk);
        end
        meas_if.valid    = 1'b1;
        meas_if.measured = meas;
        do @(posedge i_clk); while (!meas_if.ready);
        sb.note_sample(meas);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_cfg(input t_cfg c);
        apb_write(REG_SETPOINT, c.setpoint);
        apb_write(REG_GAIN_P,   {16'b0, c.gain_p});
        apb_write(REG_GAIN_I,   {16'b0, c.gain_i});
        apb_write(REG_GAIN_D,   {16'b0, c.gain_d});
        apb_write(REG_UPPER,    c.upper_limit);
        apb_write(REG_LOWER,    c.lower_limit);
        apb_write(REG_NEGATIVE, c.negative_limit);
        apb_write(REG_OFFSET,   c.drive_offset);
    endtask

    // drain every outstanding beat, then let the pipe settle
    task automatic wait_idle();
        meas_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_val corner_val();
        case ($urandom_range(5))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return t_val'($urandom);
        endcase
    endfunction

    function automatic t_gain pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return t_gain'($urandom);
            default: return t_gain'($urandom_range(16383));
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.gain_p = pick_gain();
        c.gain_i = pick_gain();
        c.gain_d = pick_gain();
        if ($urandom_range(3) == 0) begin
            c.setpoint       = corner_val();
            c.upper_limit    = corner_val();
            c.lower_limit    = corner_val();
            c.negative_limit = corner_val();
            c.drive_offset   = corner_val();
        end else begin
            // ordered windows so the loop is not pinned at a bound
            c.setpoint       = t_val'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            c.upper_limit    = t_val'($urandom_range(32'h7fff_ffff));
            c.negative_limit = -t_val'($urandom_range(32'h7fff_ffff));
            c.lower_limit    = t_val'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
            if ($urandom_range(1) == 0) begin
                c.drive_offset = '0;
            end else begin
                c.drive_offset = t_val'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
            end
        end
        return c;
    endfunction

    function automatic t_val random_sample(input t_val sp);
        case ($urandom_range(9))
            0: return corner_val();
            1: return t_val'($urandom);
            default: return sp + t_val'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    initial begin
        t_val probes[5];
        probes = '{32'sh0000_8000, 32'sh0000_8001, 32'shffff_8001,
                   32'sh7fff_8001, 32'sh8000_0000};
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        meas_if.valid    = 1'b0;
        meas_if.measured = '0;
        hold_req         = 1'b0;
        send_idle_pct    = 14;
        recv_idle_pct    = 65;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: field extremes, error and derivative saturation
        send_sample('0);
        send_sample(VAL_MAX);
        send_sample(VAL_MIN);
        send_sample(VAL_MAX);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh0001_8000);

        // reverse direction with an inverted window, full gains
        wait_idle();
        apb_write(REG_SETPOINT, -32'sd6553600);
        apb_write(REG_GAIN_P,   32'h0000_ffff);
        apb_write(REG_GAIN_I,   32'h0000_ffff);
        apb_write(REG_GAIN_D,   32'h0000_ffff);
        apb_write(REG_NEGATIVE, 32'sd3276800);
        apb_write(REG_LOWER,    -32'sd3276800);
        send_sample('0);
        send_sample(VAL_MIN);
        send_sample(VAL_MAX);
        send_sample(-32'sd6553600);

        // full window plus offset overflow, rounded output pegged high
        wait_idle();
        apb_write(REG_SETPOINT, VAL_MAX);
        apb_write(REG_UPPER,    VAL_MAX);
        apb_write(REG_LOWER,    VAL_MIN);
        apb_write(REG_GAIN_P,   32'h0000_0001);
        apb_write(REG_OFFSET,   VAL_MAX);
        send_sample(VAL_MIN);
        send_sample('0);
        send_sample(VAL_MAX);

        // zero-width window: drive equals the offset, probes the rounding
        wait_idle();
        apb_write(REG_SETPOINT, '0);
        apb_write(REG_UPPER,    '0);
        apb_write(REG_LOWER,    '0);
        foreach (probes[k]) begin
            wait_idle();
            apb_write(REG_OFFSET, probes[k]);
            send_sample(t_val'($urandom));
        end

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            wait_idle();
            load_cfg(random_cfg());
            if (seg < 7) begin
                send_idle_pct = 14;
                recv_idle_pct = 65;
            end else if (seg < 14) begin
                send_idle_pct = 65;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 0 || seg == 14) begin
                hold_req = 1'b1;
            end
            repeat (SEG_SAMPLES) send_sample(random_sample(sb.cfg.setpoint));
        end

        meas_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("pid_antiwindup_direction_clamp_top verification clean");
        end else begin
            $display("pid_antiwindup_direction_clamp_top verification failed");
        end
        $finish;
    end

endmodule
